[rtl/core/mclp_pkg.sv]
// shared types and constants for the multi-click and long-press detector
package mclp_pkg;

  localparam int NUM_KEYS  = 3;
  localparam int KEY_W     = 2;
  localparam int TIMER_W   = 17;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CLICK_W   = 4;
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = 2;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam logic [CLICK_W-1:0] CLICK_MAX = {CLICK_W{1'b1}};

  // item kinds carried on in_tuser
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // pin levels
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_STEP   = 3'd0,
    CFG_PHOTO_GAP   = 3'd1,
    CFG_PHOTO_LONG  = 3'd2,
    CFG_POWER_GAP   = 3'd3,
    CFG_POWER_LONG  = 3'd4,
    CFG_HOME_GAP    = 3'd5,
    CFG_HOME_LONG   = 3'd6
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] RST_TICK_STEP  = 16'd10;
  localparam logic [CFG_W-1:0] RST_PHOTO_GAP  = 16'd200;
  localparam logic [CFG_W-1:0] RST_PHOTO_LONG = 16'd1000;
  localparam logic [CFG_W-1:0] RST_POWER_GAP  = 16'd200;
  localparam logic [CFG_W-1:0] RST_POWER_LONG = 16'd2000;
  localparam logic [CFG_W-1:0] RST_HOME_GAP   = 16'd200;
  localparam logic [CFG_W-1:0] RST_HOME_LONG  = 16'd1000;

  // one finished gesture
  typedef struct packed {
    logic               long_press;
    logic [CLICK_W-1:0] click_count;
    logic [KEY_W-1:0]   key_index;
  } result_t;

endpackage

[rtl/core/multi_click_long_press_detector.sv]
// multi-click and long-press detector for three keys, per-key state in a small memory
// an accepted item is registered into the evaluation stage, checked there against its key's
//   state, and any result goes into the result queue, whose head drives out_tvalid
// throughput: one item per cycle when not stalled; the state memory is read at accept and
//   written in the next cycle, a bypass register covers back-to-back items on the same key
// reset (rst_n low, synchronous): config registers take their defaults, all keys idle,
//   result queue empty; memory contents are masked by per-key valid bits, no sweep
module multi_click_long_press_detector #(
  parameter int COUNT_BITS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [1:0] key_id, [2] key_level, [3] accept
  input  logic                         in_tuser,   // kind: 0 pin edge, 1 detection tick
  // result channel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [1:0] key_index, [5:2] click_count
  output logic                         out_tuser,  // long_press
  // configuration write port
  input  logic                         cfg_we,
  input  logic [mclp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mclp_pkg::CFG_W-1:0]   cfg_wdata
);

  import mclp_pkg::*;

  // width for clamping the click total onto the 4-bit result field
  localparam int CLAMP_W = (COUNT_BITS > CLICK_W) ? COUNT_BITS : CLICK_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic                  det;
    logic [TIMER_W-1:0]    gap;
    logic [COUNT_BITS-1:0] rel;
    logic [COUNT_BITS-1:0] clk_tot;
    logic [TIMER_W-1:0]    hold;
  } key_st_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] tick_step_r;
  logic [CFG_W-1:0] gap_time_r  [NUM_KEYS];
  logic [CFG_W-1:0] long_time_r [NUM_KEYS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_step_r    <= RST_TICK_STEP;
      gap_time_r[0]  <= RST_PHOTO_GAP;
      long_time_r[0] <= RST_PHOTO_LONG;
      gap_time_r[1]  <= RST_POWER_GAP;
      long_time_r[1] <= RST_POWER_LONG;
      gap_time_r[2]  <= RST_HOME_GAP;
      long_time_r[2] <= RST_HOME_LONG;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TICK_STEP:  tick_step_r    <= cfg_wdata;
        CFG_PHOTO_GAP:  gap_time_r[0]  <= cfg_wdata;
        CFG_PHOTO_LONG: long_time_r[0] <= cfg_wdata;
        CFG_POWER_GAP:  gap_time_r[1]  <= cfg_wdata;
        CFG_POWER_LONG: long_time_r[1] <= cfg_wdata;
        CFG_HOME_GAP:   gap_time_r[2]  <= cfg_wdata;
        CFG_HOME_LONG:  long_time_r[2] <= cfg_wdata;
        default: ; // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input unpacking and accept
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] in_key;
  logic             in_level;
  logic             in_accept_flag;
  logic             in_fire;
  logic             rd_en;

  assign in_key         = in_tdata[1:0];
  assign in_level       = in_tdata[2];
  assign in_accept_flag = in_tdata[3];
  assign in_fire        = in_tvalid && in_tready;
  // key three is dropped here: it never reaches the state memory
  assign rd_en          = in_fire && (in_key < KEY_W'(NUM_KEYS));

  // ---------------------------------------------------------------------------
  // per-key state memory, read at accept, written back in the next cycle
  // ---------------------------------------------------------------------------
  key_st_t          key_mem [NUM_KEYS];
  key_st_t          rd_data_r;
  logic [NUM_KEYS-1:0] key_vld_r;   // entry written since reset
  logic             rd_ok_r;
  logic             byp_vld_r;
  key_st_t          byp_data_r;

  logic             s1_vld_r;
  logic             s1_kind_r;
  logic [KEY_W-1:0] s1_key_r;
  logic             s1_level_r;
  logic             s1_accept_r;

  key_st_t          cur;
  key_st_t          st_nxt;
  logic             res_vld;
  result_t          res;

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      key_mem[s1_key_r] <= st_nxt;
    end
    if (rd_en) begin
      rd_data_r <= key_mem[in_key];
    end
  end

  // a read of the entry being written this cycle would see old data: forward it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r <= '0;
      rd_ok_r   <= 1'b0;
      byp_vld_r <= 1'b0;
      s1_vld_r  <= 1'b0;
    end else begin
      if (s1_vld_r) begin
        key_vld_r[s1_key_r] <= 1'b1;
      end
      s1_vld_r <= rd_en;
      if (rd_en) begin
        rd_ok_r   <= key_vld_r[in_key];
        byp_vld_r <= s1_vld_r && (s1_key_r == in_key);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data_r  <= st_nxt;
      s1_kind_r   <= in_tuser;
      s1_key_r    <= in_key;
      s1_level_r  <= in_level;
      s1_accept_r <= in_accept_flag;
    end
  end

  // ---------------------------------------------------------------------------
  // evaluation stage
  // ---------------------------------------------------------------------------
  logic [TIMER_W:0]    gap_sum;
  logic [TIMER_W:0]    hold_sum;
  logic [TIMER_W-1:0]  hold_new;
  logic [COUNT_BITS:0] clk_sum;
  logic [CLAMP_W-1:0]  clk_ext;
  logic [CLICK_W-1:0]  clk_out;
  logic [CFG_W-1:0]    gap_cfg;
  logic [CFG_W-1:0]    long_cfg;

  always_comb begin
    cur      = byp_vld_r ? byp_data_r : (rd_ok_r ? rd_data_r : '0);
    gap_cfg  = gap_time_r[s1_key_r];
    long_cfg = long_time_r[s1_key_r];

    gap_sum  = {1'b0, cur.gap} + (TIMER_W + 1)'(tick_step_r);
    hold_sum = {1'b0, cur.hold} + (TIMER_W + 1)'(gap_cfg);
    hold_new = hold_sum[TIMER_W] ? TIMER_MAX : hold_sum[TIMER_W-1:0];
    clk_sum  = {1'b0, cur.clk_tot} + {1'b0, cur.rel};
    clk_ext  = CLAMP_W'(cur.clk_tot);
    clk_out  = (clk_ext > CLAMP_W'(CLICK_MAX)) ? CLICK_MAX : clk_ext[CLICK_W-1:0];

    st_nxt          = cur;
    res_vld         = 1'b0;
    res.key_index   = s1_key_r;
    res.click_count = '0;
    res.long_press  = 1'b0;

    if (s1_kind_r == KIND_EDGE) begin
      if (s1_accept_r) begin
        if (!cur.det && s1_level_r == LEVEL_PRESSED) begin
          st_nxt.det = 1'b1;
        end else if (cur.det && s1_level_r == LEVEL_RELEASED) begin
          st_nxt.rel = (cur.rel == CNT_MAX) ? CNT_MAX : cur.rel + 1'b1;
        end
      end
    end else if (cur.det) begin
      if (cur.gap < TIMER_W'(gap_cfg)) begin
        // gap still running
        st_nxt.gap = gap_sum[TIMER_W] ? TIMER_MAX : gap_sum[TIMER_W-1:0];
      end else begin
        st_nxt.gap = '0;
        if (cur.rel != '0) begin
          // new releases in this gap fold into the click total
          st_nxt.clk_tot = clk_sum[COUNT_BITS] ? CNT_MAX : clk_sum[COUNT_BITS-1:0];
          st_nxt.hold    = '0;
          st_nxt.rel     = '0;
        end else if (s1_level_r == LEVEL_PRESSED) begin
          // still held: grow hold time, long press once it reaches the limit
          st_nxt.hold    = hold_new;
          st_nxt.clk_tot = '0;
          if (hold_new >= TIMER_W'(long_cfg)) begin
            st_nxt         = '0;
            res_vld        = 1'b1;
            res.long_press = 1'b1;
          end
        end else begin
          // released and quiet for a whole gap: gesture done
          st_nxt          = '0;
          res_vld         = 1'b1;
          res.click_count = clk_out;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result queue, three entries so the evaluation stage never has to stall
  // ---------------------------------------------------------------------------
  result_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] head_r;
  logic [FIFO_PTR_W-1:0] tail_r;
  logic [FIFO_PTR_W-1:0] cnt_r;
  logic                  enq;
  logic                  deq;

  assign enq = s1_vld_r && res_vld;
  assign deq = out_tvalid && out_tready;

  // room for the item in flight plus a new one
  assign in_tready = ({1'b0, cnt_r} + (FIFO_PTR_W + 1)'(s1_vld_r)) <
                     (FIFO_PTR_W + 1)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (enq) begin
      fifo_q[tail_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (enq) begin
        tail_r <= (tail_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      end
      if (deq) begin
        head_r <= (head_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
      end
      case ({enq, deq})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  result_t head_item;
  assign head_item  = fifo_q[head_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {2'b00, head_item.click_count, head_item.key_index};
  assign out_tuser  = head_item.long_press;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a result from the evaluation stage always finds room in the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    enq |-> (cnt_r != FIFO_PTR_W'(FIFO_DEPTH)) || deq)
    else $error("result queue overflow");

  // long-press results never carry clicks
  a_long_no_clicks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[5:2] == 4'd0))
    else $error("long press with nonzero click count");

  // the input side only backs off while results or an item are pending
  a_ready_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (cnt_r != '0))
    else $error("input stalled with empty queue");

  // a read of the key that stage one is writing always gets the forwarded state
  a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && s1_vld_r && (s1_key_r == in_key)) |=> byp_vld_r)
    else $error("same-key back-to-back item missed the bypass");

endmodule
